// File: hdl/lbpt_pkg.sv
// Package: shared constants, register map and result type of the LED blink pattern timer.
package lbpt_pkg;

  localparam int unsigned PATTERN_COUNT_DEF = 10;

  localparam int unsigned STEP_DELAY_W    = 16;
  localparam int unsigned PATTERN_PAUSE_W = 8;
  localparam int unsigned BLINK_COUNT_W   = 4;
  localparam int unsigned FAST_ELAPSED_W  = 17;
  localparam int unsigned SLOW_ELAPSED_W  = 18;
  localparam int unsigned POSITION_W      = 8;
  localparam int unsigned LENGTH_W        = 9;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [STEP_DELAY_W-1:0]    STEP_DELAY_RST    = 16'd125;
  localparam logic [PATTERN_PAUSE_W-1:0] PATTERN_PAUSE_RST = 8'd6;

  typedef enum logic {
    REG_STEP_DELAY    = 1'b0,
    REG_PATTERN_PAUSE = 1'b1
  } lbpt_reg_e;

  typedef struct packed {
    logic blink_on;
    logic slow_blink_on;
    logic pattern_on;
    logic changed;
  } lbpt_res_t;

endpackage

// File: hdl/led_blink_pattern_timer.sv
// LED blink pattern timer: tick counters, pattern positions, APB registers and result buffer.
// Results are registered: a tick beat accepted at one edge shows on the outputs after that edge unless out stalls.
// Throughput: one tick beat per cycle while in_stall_o is low; counters and all pattern positions update in one pass.
// A two-entry result buffer (output register plus skid) takes one more beat while out stalls.
// in_stall_o depends on the skid register only, never combinationally on out_stall_i.
// Reset: rst_ni clears counters, flags, positions and buffer valid bits; registers load 125 and 6.
module led_blink_pattern_timer
  import lbpt_pkg::*;
#(
  parameter int unsigned PATTERN_COUNT = PATTERN_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [BLINK_COUNT_W-1:0]   blink_count_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       blink_on_o,
  output logic                       slow_blink_on_o,
  output logic                       pattern_on_o,
  output logic                       changed_o
);

  logic [STEP_DELAY_W-1:0]    step_delay_q;
  logic [PATTERN_PAUSE_W-1:0] pattern_pause_q;
  logic [FAST_ELAPSED_W-1:0]  fast_elapsed_q, fast_elapsed_d, fast_inc;
  logic [SLOW_ELAPSED_W-1:0]  slow_elapsed_q, slow_elapsed_d, slow_inc;
  logic                       fast_flag_q, fast_flag_d;
  logic                       slow_flag_q, slow_flag_d;
  logic [POSITION_W-1:0]      pos_q [PATTERN_COUNT];
  logic [POSITION_W-1:0]      pos_d [PATTERN_COUNT];
  logic [POSITION_W-1:0]      pos_sel;
  logic                       sel_hit;
  logic                       fast_tgl, slow_tgl;
  logic                       in_acc, cfg_wr;
  lbpt_res_t                  res, out_q, out_d, skid_q, skid_d;
  logic                       out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    unique case (lbpt_reg_e'(paddr[2]))
      REG_STEP_DELAY:    prdata = {{(APB_DATA_W-STEP_DELAY_W){1'b0}}, step_delay_q};
      REG_PATTERN_PAUSE: prdata = {{(APB_DATA_W-PATTERN_PAUSE_W){1'b0}}, pattern_pause_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_delay_q    <= STEP_DELAY_RST;
      pattern_pause_q <= PATTERN_PAUSE_RST;
    end else if (cfg_wr) begin
      unique case (lbpt_reg_e'(paddr[2]))
        REG_STEP_DELAY:    step_delay_q    <= pwdata[STEP_DELAY_W-1:0];
        REG_PATTERN_PAUSE: pattern_pause_q <= pwdata[PATTERN_PAUSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // tick update
  always_comb begin
    logic [POSITION_W-1:0] nxt;
    logic [LENGTH_W-1:0]   len;
    fast_inc = (fast_elapsed_q == '1) ? fast_elapsed_q : fast_elapsed_q + 1'b1;
    slow_inc = (slow_elapsed_q == '1) ? slow_elapsed_q : slow_elapsed_q + 1'b1;
    fast_tgl = fast_inc >= {step_delay_q, 1'b0};
    slow_tgl = slow_inc >= {step_delay_q, 2'b00};
    fast_elapsed_d = fast_tgl ? '0 : fast_inc;
    slow_elapsed_d = slow_tgl ? '0 : slow_inc;
    fast_flag_d    = fast_flag_q ^ fast_tgl;
    slow_flag_d    = slow_flag_q ^ slow_tgl;
    pos_sel = '0;
    sel_hit = 1'b0;
    for (int i = 0; i < PATTERN_COUNT; i++) begin
      len = LENGTH_W'(2 * (i + 1)) + {1'b0, pattern_pause_q};
      nxt = pos_q[i] + 1'b1;
      if ({1'b0, nxt} >= len) begin
        nxt = '0;
      end
      pos_d[i] = fast_tgl ? nxt : pos_q[i];
      if (blink_count_i == BLINK_COUNT_W'(i + 1)) begin
        pos_sel = pos_d[i];
        sel_hit = 1'b1;
      end
    end
    res.blink_on      = fast_flag_d;
    res.slow_blink_on = slow_flag_d;
    res.pattern_on    = sel_hit & ({1'b0, pos_sel} < {4'b0000, blink_count_i, 1'b0})
                        & ~pos_sel[0];
    res.changed       = fast_tgl | slow_tgl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_elapsed_q <= '0;
      slow_elapsed_q <= '0;
      fast_flag_q    <= 1'b0;
      slow_flag_q    <= 1'b0;
      for (int i = 0; i < PATTERN_COUNT; i++) begin
        pos_q[i] <= '0;
      end
    end else if (in_acc) begin
      fast_elapsed_q <= fast_elapsed_d;
      slow_elapsed_q <= slow_elapsed_d;
      fast_flag_q    <= fast_flag_d;
      slow_flag_q    <= slow_flag_d;
      pos_q          <= pos_d;
    end
  end

  // result buffer
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = in_acc;
      end
    end else if (in_acc) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign blink_on_o      = out_q.blink_on;
  assign slow_blink_on_o = out_q.slow_blink_on;
  assign pattern_on_o    = out_q.pattern_on;
  assign changed_o       = out_q.changed;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while the output register is empty");

  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.changed) |=>
      (fast_flag_q != $past(fast_flag_q)) || (slow_flag_q != $past(slow_flag_q)))
    else $error("changed beat without a flag toggle");

  a_fast_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fast_tgl) |=> (fast_elapsed_q == '0))
    else $error("fast counter not cleared on toggle");

  a_pattern_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.pattern_on |-> (blink_count_i != '0) &&
                       ({28'd0, blink_count_i} <= 32'(PATTERN_COUNT)))
    else $error("lamp on for a blink count out of range");

endmodule
